// ===== sv/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants of the marginal regression slope block.
// ----------------------------------------------------------------------------
package mrs_pkg;

  localparam int MAX_OBS_DEF = 32768;
  localparam int X_W         = 24;
  localparam int SUMX_W      = 40;
  localparam int SUMQ_W      = 64;
  localparam int PROD_W      = 2 * X_W;
  localparam int ALU_W       = 224;
  localparam int RES_FRAC    = 24;
  localparam int OUT_W       = 48;
  localparam int STD_W       = 47;

  localparam logic [ALU_W-1:0] POS_LIM = ALU_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [ALU_W-1:0] NEG_LIM = ALU_W'(48'h8000_0000_0000);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_FLAT  = 2'd2,
    ST_EXACT = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    logic    sub;
  } alu_req_t;

  typedef struct packed {
    logic start;
    logic pair;
    logic clear;
  } acc_ctl_t;

  function automatic logic [ALU_W-1:0] sat(input logic [ALU_W-1:0] v,
                                           input logic [ALU_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ===== sv/mrs_accum.sv =====
// ----------------------------------------------------------------------------
// mrs_accum
// Pair count and running sums, one shared 24x24 multiplier over three steps.
// ----------------------------------------------------------------------------
module mrs_accum #(
  parameter int MAX_OBS = mrs_pkg::MAX_OBS_DEF,
  parameter int CNT_W   = $clog2(MAX_OBS + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mrs_pkg::acc_ctl_t                  ctl_i,
  input  logic signed [mrs_pkg::X_W-1:0]     x_i,
  input  logic signed [mrs_pkg::X_W-1:0]     y_i,
  output logic                               busy_o,
  output logic [CNT_W-1:0]                   count_o,
  output logic [mrs_pkg::SUMX_W-1:0]         sum_x_o,
  output logic [mrs_pkg::SUMX_W-1:0]         sum_y_o,
  output logic [mrs_pkg::SUMQ_W-1:0]         sum_xx_o,
  output logic [mrs_pkg::SUMQ_W-1:0]         sum_xy_o,
  output logic [mrs_pkg::SUMQ_W-1:0]         sum_yy_o
);
  import mrs_pkg::*;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_XX   = 5'b00010,
    A_XY   = 5'b00100,
    A_YY   = 5'b01000,
    A_ADD  = 5'b10000
  } acc_state_e;

  acc_state_e state_q, state_d;
  logic signed [X_W-1:0]    x_q, y_q, ma, mb;
  logic signed [PROD_W-1:0] prod_q;
  logic [SUMQ_W-1:0]        prod_ext;
  logic [CNT_W-1:0]         count_q;
  logic [SUMX_W-1:0]        sum_x_q, sum_y_q;
  logic [SUMQ_W-1:0]        sum_xx_q, sum_xy_q, sum_yy_q;
  logic                     take;

  assign take     = ctl_i.start && ctl_i.pair && (count_q < CNT_W'(MAX_OBS));
  assign ma       = (state_q == A_YY) ? y_q : x_q;
  assign mb       = (state_q == A_XX) ? x_q : y_q;
  assign prod_ext = {{(SUMQ_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      A_IDLE: if (take) state_d = A_XX;
      A_XX:   state_d = A_XY;
      A_XY:   state_d = A_YY;
      A_YY:   state_d = A_ADD;
      A_ADD:  state_d = A_IDLE;
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= A_IDLE;
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      sum_yy_q <= '0;
    end else if (ctl_i.clear) begin
      state_q  <= A_IDLE;
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_xy_q <= '0;
      sum_yy_q <= '0;
    end else begin
      state_q <= state_d;
      if (take) begin
        count_q <= count_q + CNT_W'(1);
        sum_x_q <= sum_x_q + {{(SUMX_W-X_W){x_i[X_W-1]}}, x_i};
        sum_y_q <= sum_y_q + {{(SUMX_W-X_W){y_i[X_W-1]}}, y_i};
      end
      case (state_q)
        A_XY:  sum_xx_q <= sum_xx_q + prod_ext;
        A_YY:  sum_xy_q <= sum_xy_q + prod_ext;
        A_ADD: sum_yy_q <= sum_yy_q + prod_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q <= x_i;
      y_q <= y_i;
    end
    prod_q <= ma * mb;
  end

  assign busy_o   = (state_q != A_IDLE);
  assign count_o  = count_q;
  assign sum_x_o  = sum_x_q;
  assign sum_y_o  = sum_y_q;
  assign sum_xx_o = sum_xx_q;
  assign sum_xy_o = sum_xy_q;
  assign sum_yy_o = sum_yy_q;

endmodule

// ===== sv/mrs_alu.sv =====
// ----------------------------------------------------------------------------
// mrs_alu
// Wide serial unit: shift-add multiply-accumulate, restoring divide and
// digit-by-digit square root over one shared adder.
// ----------------------------------------------------------------------------
module mrs_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mrs_pkg::alu_req_t          req_i,
  input  logic [mrs_pkg::ALU_W-1:0]  a_i,
  input  logic [mrs_pkg::ALU_W-1:0]  b_i,
  input  logic [mrs_pkg::ALU_W-1:0]  c_i,
  output logic                       done_o,
  output logic [mrs_pkg::ALU_W-1:0]  res_o
);
  import mrs_pkg::*;

  localparam int W  = ALU_W;
  localparam int CW = $clog2(W + 1);

  alu_op_e        op_q;
  logic           sub_q, busy_q, done_q;
  logic [CW-1:0]  cnt_q;
  logic [W-1:0]   acc_q, opa_q, opb_q;
  logic [W:0]     rem_q, trial, add_x, add_y;
  logic [W+1:0]   sum;
  logic           inv, ge, last_it;

  always_comb begin
    trial = (op_q == OP_SQRT) ? {rem_q[W-2:0], acc_q[W-1:W-2]}
                              : {rem_q[W-1:0], acc_q[W-1]};
    case (op_q)
      OP_MUL: begin
        add_x = {1'b0, acc_q};
        add_y = {1'b0, opa_q};
        inv   = sub_q;
      end
      OP_DIV: begin
        add_x = trial;
        add_y = {1'b0, opb_q};
        inv   = 1'b1;
      end
      default: begin
        add_x = trial;
        add_y = {opa_q[W-2:0], 2'b01};
        inv   = 1'b1;
      end
    endcase
    sum     = {1'b0, add_x} + {1'b0, add_y ^ {(W+1){inv}}} + (W+2)'(inv);
    ge      = sum[W+1];
    last_it = (cnt_q == CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if ((op_q == OP_MUL) ? (opb_q == '0) : last_it) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      op_q  <= req_i.op;
      sub_q <= req_i.sub;
      rem_q <= '0;
      cnt_q <= (req_i.op == OP_DIV) ? CW'(W) : CW'(W / 2);
      case (req_i.op)
        OP_MUL: begin
          acc_q <= c_i;
          opa_q <= a_i;
          opb_q <= b_i;
        end
        OP_DIV: begin
          acc_q <= a_i;
          opb_q <= b_i;
        end
        default: begin
          acc_q <= a_i;
          opa_q <= '0;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        OP_MUL: begin
          if (opb_q[0]) acc_q <= sum[W-1:0];
          opa_q <= {opa_q[W-2:0], 1'b0};
          opb_q <= {1'b0, opb_q[W-1:1]};
        end
        OP_DIV: begin
          rem_q <= ge ? sum[W:0] : trial;
          acc_q <= {acc_q[W-2:0], ge};
          cnt_q <= cnt_q - CW'(1);
        end
        default: begin
          rem_q <= ge ? sum[W:0] : trial;
          acc_q <= {acc_q[W-3:0], 2'b00};
          opa_q <= {opa_q[W-2:0], ge};
          cnt_q <= cnt_q - CW'(1);
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_SQRT) ? opa_q : acc_q;

endmodule

// ===== sv/marginal_regression_slope.sv =====
// ----------------------------------------------------------------------------
// marginal_regression_slope
// Least-squares slope, standard error and t statistic of one column.
// ----------------------------------------------------------------------------
// Observations are taken one per transaction. A complete pair holds the
// input longer than an incomplete one, as the accumulator's single 24x24
// multiplier is used for x*x, x*y and y*y in turn. The transaction with tlast
// starts the finishing pass, which runs on one 224-bit serial unit: each
// multiply steps through the significant bits of its second operand, and
// each divide and square root works one result bit at a time. The input is
// not ready during that time; a finished result waits in the output register
// while the next column is accumulated. Status in m_axis_tuser: 0 ok, 1 too
// few pairs, 2 zero x spread, 3 zero residual.
module marginal_regression_slope #(
  parameter int MAX_OBS = mrs_pkg::MAX_OBS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,   // x_value[23:0], y_value[47:24]
  input  logic [1:0]   s_axis_tuser,   // x_finite[0], y_finite[1]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,   // slope[47:0], std_error[94:48],
                                       // t_statistic[142:95], zero[143]
  output logic [1:0]   m_axis_tuser,   // status[1:0]
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i
);
  import mrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_OBS + 1);
  localparam int W     = ALU_W;

  typedef enum logic [23:0] {
    S_IDLE = 24'd1,       S_ACC  = 24'd2,       S_LOAD = 24'd4,
    S_MXX  = 24'd8,       S_SXX  = 24'd16,      S_MXY  = 24'd32,
    S_SXY  = 24'd64,      S_MYY  = 24'd128,     S_SYY  = 24'd256,
    S_CHK  = 24'd512,     S_ABS  = 24'd1024,    S_SLP  = 24'd2048,
    S_DSX  = 24'd4096,    S_DAA  = 24'd8192,    S_DSB  = 24'd16384,
    S_CHKD = 24'd32768,   S_SQXX = 24'd65536,   S_DFXX = 24'd131072,
    S_DIVS = 24'd262144,  S_SQRS = 24'd524288,  S_DFAA = 24'd1048576,
    S_DIVT = 24'd2097152, S_SQT  = 24'd4194304, S_OUT  = 24'd8388608
  } state_e;

  state_e state_q, state_d;
  logic   go_q, ic_q, out_valid_q, last_q, neg_q;
  logic   s_acc, alu_state, alu_done, acc_busy, few, out_load;

  acc_ctl_t   acc_ctl;
  alu_req_t   alu_req;
  logic [W-1:0] alu_a, alu_b, alu_c, alu_res;
  logic [W-1:0] sxx_q, sxy_q, syy_q, d_q, aa_q, tmp_q;
  logic [W-1:0] m_w, df_w, sx_w, sy_w, one_w, sat_lim, sat_v, std_v;
  logic [CNT_W-1:0]  count, df_c, min_c;
  logic [SUMX_W-1:0] sum_x, sum_y;
  logic [SUMQ_W-1:0] sum_xx, sum_xy, sum_yy;
  logic [OUT_W-1:0]  mag, sgn, res_slope_q, res_t_q, out_slope_q, out_t_q;
  logic [STD_W-1:0]  res_std_q, out_std_q;
  status_e           res_status_q, out_status_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_axis_tready);

  assign acc_ctl.start = s_acc;
  assign acc_ctl.pair  = s_axis_tuser[0] && s_axis_tuser[1];
  assign acc_ctl.clear = out_load;

  mrs_accum #(
    .MAX_OBS(MAX_OBS),
    .CNT_W  (CNT_W)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (acc_ctl),
    .x_i     (s_axis_tdata[23:0]),
    .y_i     (s_axis_tdata[47:24]),
    .busy_o  (acc_busy),
    .count_o (count),
    .sum_x_o (sum_x),
    .sum_y_o (sum_y),
    .sum_xx_o(sum_xx),
    .sum_xy_o(sum_xy),
    .sum_yy_o(sum_yy)
  );

  mrs_alu u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .c_i   (alu_c),
    .done_o(alu_done),
    .res_o (alu_res)
  );

  assign min_c = ic_q ? CNT_W'(2) : CNT_W'(1);
  assign few   = (count <= min_c);
  assign df_c  = count - min_c;
  assign m_w   = W'(count);
  assign df_w  = W'(df_c);
  assign one_w = W'(1);
  assign sx_w  = {{(W-SUMX_W){sum_x[SUMX_W-1]}}, sum_x};
  assign sy_w  = {{(W-SUMX_W){sum_y[SUMX_W-1]}}, sum_y};

  assign sat_lim = neg_q ? NEG_LIM : POS_LIM;
  assign sat_v   = sat(alu_res, sat_lim);
  assign std_v   = sat(alu_res, POS_LIM);
  assign mag     = sat_v[OUT_W-1:0];
  assign sgn     = neg_q ? (OUT_W'(0) - mag) : mag;

  always_comb begin
    alu_a     = '0;
    alu_b     = '0;
    alu_c     = '0;
    alu_req.op  = OP_MUL;
    alu_req.sub = 1'b0;
    alu_state = 1'b1;
    case (state_q)
      S_MXX:  begin alu_a = m_w;  alu_b = sxx_q; end
      S_SXX:  begin alu_a = sx_w; alu_b = sx_w; alu_c = sxx_q; alu_req.sub = 1'b1; end
      S_MXY:  begin alu_a = m_w;  alu_b = sxy_q; end
      S_SXY:  begin alu_a = sx_w; alu_b = sy_w; alu_c = sxy_q; alu_req.sub = 1'b1; end
      S_MYY:  begin alu_a = m_w;  alu_b = syy_q; end
      S_SYY:  begin alu_a = sy_w; alu_b = sy_w; alu_c = syy_q; alu_req.sub = 1'b1; end
      S_ABS:  begin alu_a = sxy_q; alu_b = one_w; alu_req.sub = neg_q; end
      S_SLP:  begin
        alu_a = {sxy_q[W-1-RES_FRAC:0], {RES_FRAC{1'b0}}};
        alu_b = sxx_q;
        alu_req.op = OP_DIV;
      end
      S_DSX:  begin alu_a = syy_q; alu_b = sxx_q; end
      S_DAA:  begin alu_a = sxy_q; alu_b = sxy_q; end
      S_DSB:  begin alu_a = aa_q; alu_b = one_w; alu_c = d_q; alu_req.sub = 1'b1; end
      S_SQXX: begin alu_a = sxx_q; alu_b = sxx_q; end
      S_DFXX: begin alu_a = tmp_q; alu_b = df_w; end
      S_DIVS: begin
        alu_a = {d_q[W-1-2*RES_FRAC:0], {(2*RES_FRAC){1'b0}}};
        alu_b = tmp_q;
        alu_req.op = OP_DIV;
      end
      S_SQRS: begin alu_a = tmp_q; alu_req.op = OP_SQRT; end
      S_DFAA: begin alu_a = aa_q; alu_b = df_w; end
      S_DIVT: begin
        alu_a = {tmp_q[W-1-2*RES_FRAC:0], {(2*RES_FRAC){1'b0}}};
        alu_b = d_q;
        alu_req.op = OP_DIV;
      end
      S_SQT:  begin alu_a = tmp_q; alu_req.op = OP_SQRT; end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = go_q && alu_state;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_acc) state_d = S_ACC;
      S_ACC:  if (!acc_busy) state_d = last_q ? S_LOAD : S_IDLE;
      S_LOAD: state_d = few ? S_OUT : (ic_q ? S_MXX : S_CHK);
      S_MXX:  if (alu_done) state_d = S_SXX;
      S_SXX:  if (alu_done) state_d = S_MXY;
      S_MXY:  if (alu_done) state_d = S_SXY;
      S_SXY:  if (alu_done) state_d = S_MYY;
      S_MYY:  if (alu_done) state_d = S_SYY;
      S_SYY:  if (alu_done) state_d = S_CHK;
      S_CHK:  state_d = (sxx_q == '0) ? S_OUT : S_ABS;
      S_ABS:  if (alu_done) state_d = S_SLP;
      S_SLP:  if (alu_done) state_d = S_DSX;
      S_DSX:  if (alu_done) state_d = S_DAA;
      S_DAA:  if (alu_done) state_d = S_DSB;
      S_DSB:  if (alu_done) state_d = S_CHKD;
      S_CHKD: state_d = (d_q == '0) ? S_OUT : S_SQXX;
      S_SQXX: if (alu_done) state_d = S_DFXX;
      S_DFXX: if (alu_done) state_d = S_DIVS;
      S_DIVS: if (alu_done) state_d = S_SQRS;
      S_SQRS: if (alu_done) state_d = S_DFAA;
      S_DFAA: if (alu_done) state_d = S_DIVT;
      S_DIVT: if (alu_done) state_d = S_SQT;
      S_SQT:  if (alu_done) state_d = S_OUT;
      S_OUT:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      ic_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= (state_d != state_q);
      if (cfg_we_i) ic_q <= cfg_wdata_i;
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) last_q <= s_axis_tlast;
    case (state_q)
      S_LOAD: begin
        sxx_q        <= {{(W-SUMQ_W){sum_xx[SUMQ_W-1]}}, sum_xx};
        sxy_q        <= {{(W-SUMQ_W){sum_xy[SUMQ_W-1]}}, sum_xy};
        syy_q        <= {{(W-SUMQ_W){sum_yy[SUMQ_W-1]}}, sum_yy};
        res_slope_q  <= '0;
        res_std_q    <= '0;
        res_t_q      <= '0;
        res_status_q <= few ? ST_FEW : ST_OK;
      end
      S_CHK: begin
        neg_q <= sxy_q[W-1];
        if (sxx_q == '0) res_status_q <= ST_FLAT;
      end
      S_CHKD: begin
        if (d_q == '0) begin
          res_status_q <= ST_EXACT;
          if (sxy_q != '0) res_t_q <= neg_q ? NEG_LIM[OUT_W-1:0] : POS_LIM[OUT_W-1:0];
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_slope_q  <= res_slope_q;
          out_std_q    <= res_std_q;
          out_t_q      <= res_t_q;
          out_status_q <= res_status_q;
        end
      end
      default: ;
    endcase
    if (alu_done) begin
      case (state_q)
        S_MXX, S_SXX: sxx_q <= alu_res;
        S_MXY, S_SXY, S_ABS: sxy_q <= alu_res;
        S_MYY, S_SYY: syy_q <= alu_res;
        S_SLP:  res_slope_q <= sgn;
        S_DSX, S_DSB: d_q <= alu_res;
        S_DAA:  aa_q <= alu_res;
        S_SQXX, S_DFXX, S_DIVS, S_DFAA, S_DIVT: tmp_q <= alu_res;
        S_SQRS: res_std_q <= std_v[STD_W-1:0];
        S_SQT:  res_t_q <= sgn;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_t_q, out_std_q, out_slope_q};
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for marginal_regression_slope: a directed table of
// columns, then random columns (few pairs, flat x, exact lines, noisy lines,
// sparse finite flags) under both fit modes, with random idling on both
// streams, checked against a wide-integer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mrs_pkg::*;

  localparam logic [47:0] SLOPE_POS = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SLOPE_NEG = 48'h8000_0000_0000;
  localparam logic [47:0] ONE       = 48'h0000_0100_0000;
  localparam int          DRAIN     = 3000;

  typedef struct {
    logic [47:0] slope;
    logic [46:0] se;
    logic [47:0] tst;
    status_e     st;
  } fit_t;

  typedef struct {
    bit          icpt;
    int          x;
    bit          xf;
    int          y;
    bit          yf;
    bit          last;
    bit          typed;
    fit_t        res;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_we_i = 1'b0;
  logic         cfg_wdata_i = 1'b0;

  fit_t        fits_due[$];
  int          errors = 0;
  bit          tx_burst = 0;
  bit          rx_burst = 0;
  bit          rx_hold = 0;
  bit          pending = 0;

  // model state
  bit                 icpt = 1'b1;
  int unsigned        cnt = 0;
  logic signed [63:0] sx = 0, sy = 0, sxx = 0, sxy = 0, syy = 0;

  marginal_regression_slope dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #1_000_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [255:0] isqrt(input logic [255:0] v);
    logic [255:0] r, c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (256'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [47:0] clip(input logic [255:0] v, input logic [47:0] lim);
    return (v > {208'd0, lim}) ? lim : v[47:0];
  endfunction

  function automatic void clear_sums();
    cnt = 0;
    sx = 0; sy = 0; sxx = 0; sxy = 0; syy = 0;
  endfunction

  // returns 1 when the observation closes a column
  function automatic bit fit_obs(input int x, input bit xf, input int y, input bit yf,
                                 input bit last, output fit_t r);
    logic signed [255:0] bx, by, bxx, bxy, byy, m;
    logic [255:0]        a, d, df, q;
    logic [47:0]         mag;
    bit                  neg;
    logic signed [63:0]  lx, ly;
    lx = x;
    ly = y;
    r.slope = '0; r.se = '0; r.tst = '0; r.st = ST_FEW;
    if (xf && yf && cnt < MAX_OBS_DEF) begin
      cnt++;
      sx += lx; sy += ly; sxx += lx * lx; sxy += lx * ly; syy += ly * ly;
    end
    if (!last) return 0;
    if (cnt <= (icpt ? 2 : 1)) begin
      clear_sums();
      return 1;
    end
    df = cnt - (icpt ? 2 : 1);
    m = cnt; bx = sx; by = sy; bxx = sxx; bxy = sxy; byy = syy;
    if (icpt) begin
      bxx = m * bxx - bx * bx;
      bxy = m * bxy - bx * by;
      byy = m * byy - by * by;
    end
    clear_sums();
    if (bxx == 0) begin
      r.st = ST_FLAT;
      return 1;
    end
    neg = bxy < 0;
    a = neg ? -bxy : bxy;
    q = (a << RES_FRAC) / bxx;
    mag = clip(q, neg ? SLOPE_NEG : SLOPE_POS);
    r.slope = neg ? -mag : mag;
    d = byy * bxx - a * a;
    if (d == 0) begin
      r.st = ST_EXACT;
      if (a != 0) r.tst = neg ? SLOPE_NEG : SLOPE_POS;
      return 1;
    end
    r.se = 47'(clip(isqrt((d << 48) / (df * bxx * bxx)), SLOPE_POS));
    mag = clip(isqrt(((a * a * df) << 48) / d), neg ? SLOPE_NEG : SLOPE_POS);
    r.tst = neg ? -mag : mag;
    r.st = ST_OK;
    return 1;
  endfunction

  // result side
  always @(posedge clk_i) begin
    fit_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (fits_due.size() == 0) begin
        $display("%0t unexpected result %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = fits_due.pop_front();
        if (m_axis_tdata[47:0] !== e.slope || m_axis_tdata[94:48] !== e.se ||
            m_axis_tdata[142:95] !== e.tst || m_axis_tuser !== e.st) begin
          $display("%0t mismatch exp slope %h se %h t %h st %0d", $time, e.slope, e.se,
                   e.tst, e.st);
          $display("%0t          got slope %h se %h t %h st %0d", $time,
                   m_axis_tdata[47:0], m_axis_tdata[94:48], m_axis_tdata[142:95],
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (4000) @(posedge clk_i);
        rx_hold = 0;
      end
      n = rx_burst ? 0 : $urandom_range(0, 19);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic send(input int x, input bit xf, input int y, input bit yf, input bit last,
                      input bit typed, input fit_t t);
    int   gap;
    fit_t r;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {y[23:0], x[23:0]};
    s_axis_tuser  <= {yf, xf};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending = 1;
    if (fit_obs(x, xf, y, yf, last, r)) fits_due.push_back(typed ? t : r);
  endtask

  task automatic settle();
    if (pending) s_axis_tvalid <= 1'b0;
    pending = 0;
    @(posedge clk_i);
    while (fits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_fit(input bit v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    icpt = v;
  endtask

  function automatic int sx24(input int v);
    return {{8{v[23]}}, v[23:0]};
  endfunction

  row_t dir[$];
  fit_t nofit;

  function automatic row_t mk(input bit ic, input int x, input bit xf, input int y,
                              input bit yf, input bit last);
    row_t r;
    r.icpt = ic; r.x = x; r.xf = xf; r.y = y; r.yf = yf; r.last = last;
    r.typed = 0; r.res = '{default: '0, st: ST_OK};
    return r;
  endfunction

  function automatic row_t mkt(input row_t r, input logic [47:0] s, input logic [47:0] t,
                               input status_e st);
    r.typed = 1;
    r.res.slope = s; r.res.se = '0; r.res.tst = t; r.res.st = st;
    return r;
  endfunction

  initial begin
    int items, len, mode, k, x, y, ph;
    bit xf, yf;
    nofit = '{default: '0, st: ST_OK};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir.push_back(mkt(mk(1, 100, 1, 200, 1, 1), '0, '0, ST_FEW));
    dir.push_back(mkt(mk(1, 0, 0, 5, 1, 1), '0, '0, ST_FEW));
    dir.push_back(mk(1, 8388607, 1, -8388608, 1, 0));
    dir.push_back(mk(1, 8388607, 1, 0, 1, 0));
    dir.push_back(mkt(mk(1, 8388607, 1, 8388607, 1, 1), '0, '0, ST_FLAT));
    dir.push_back(mk(1, 4096, 1, 4096, 1, 0));
    dir.push_back(mk(1, 8192, 1, 8192, 1, 0));
    dir.push_back(mkt(mk(1, 12288, 1, 12288, 1, 1), ONE, SLOPE_POS, ST_EXACT));
    dir.push_back(mk(1, 1, 1, -1, 1, 0));
    dir.push_back(mk(1, 2, 1, -2, 1, 0));
    dir.push_back(mkt(mk(1, 3, 1, -3, 1, 1), -ONE, SLOPE_NEG, ST_EXACT));
    dir.push_back(mk(1, -5, 1, 3, 1, 0));
    dir.push_back(mk(1, 0, 1, 3, 1, 0));
    dir.push_back(mkt(mk(1, 7, 1, 3, 1, 1), '0, '0, ST_EXACT));
    dir.push_back(mk(1, -8388608, 1, 8388607, 1, 0));
    dir.push_back(mk(1, 8388607, 1, -8388608, 1, 0));
    dir.push_back(mk(1, 0, 1, 1, 0, 0));
    dir.push_back(mk(1, 123, 0, 456, 1, 0));
    dir.push_back(mk(1, -1, 1, -1, 1, 0));
    dir.push_back(mk(1, 1, 1, 0, 1, 1));
    dir.push_back(mkt(mk(0, 5, 1, 9, 1, 1), '0, '0, ST_FEW));
    dir.push_back(mk(0, 0, 1, 3, 1, 0));
    dir.push_back(mkt(mk(0, 0, 1, -3, 1, 1), '0, '0, ST_FLAT));
    dir.push_back(mk(0, -8388608, 1, 8388607, 1, 0));
    dir.push_back(mk(0, 8388607, 1, 8388607, 1, 1));

    foreach (dir[i]) begin
      if (dir[i].icpt != icpt) set_fit(dir[i].icpt);
      send(dir[i].x, dir[i].xf, dir[i].y, dir[i].yf, dir[i].last, dir[i].typed, dir[i].res);
    end

    items = 0;
    ph = 0;
    while (items < 1850) begin
      if (items >= ph * 300) begin
        set_fit(ph % 2 == 1);
        if (ph == 2) rx_hold = 1;
        ph++;
      end
      tx_burst = $urandom_range(0, 5) == 0;
      rx_burst = $urandom_range(0, 5) == 0;
      k = $urandom_range(0, 99);
      len = k < 80 ? $urandom_range(1, 25) : (k < 95 ? $urandom_range(26, 120) :
                                              $urandom_range(1, 3));
      mode = $urandom_range(0, 5);
      k = $urandom_range(0, 200) - 100;
      x = sx24($urandom);
      for (int i = 0; i < len; i++) begin
        xf = 1; yf = 1;
        case (mode)
          0: begin x = sx24($urandom); y = sx24($urandom); end
          1: begin x = $urandom_range(0, 64) - 32; y = $urandom_range(0, 64) - 32; end
          2: begin
            x = $urandom_range(0, 20000) - 10000;
            y = x * k + $urandom_range(0, 8) - 4;
          end
          3: y = sx24($urandom);
          4: begin x = $urandom_range(0, 20000) - 10000; y = x * k; end
          default: begin
            x = sx24($urandom); y = sx24($urandom);
            xf = $urandom_range(0, 2) != 0; yf = $urandom_range(0, 2) != 0;
          end
        endcase
        if ($urandom_range(0, 19) == 0) xf = 0;
        send(x, xf, y, yf, i == len - 1, 0, nofit);
        items++;
      end
    end

    settle();
    if (errors == 0 && fits_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
